[hdl/ptib_pkg.sv]
// Shared types and fixed constants for the triangle point test / barycentric weights block.
// No dependencies.
package ptib_pkg;

    // Width of every weight result (signed, Q3.16 at the default fraction width)
    localparam int WEIGHT_BITS = 20;

    // Sign and overflow tags that ride along one divider lane
    typedef struct packed {
        logic neg;
        logic ovf;
    } t_div_ctl;

    // Flags that bypass the dividers
    typedef struct packed {
        logic in_tri;
        logic degen;
    } t_side;

endpackage

[hdl/ptib_if.sv]
// Valid/ready channel interfaces for the sample words and the result words.
// Depends on ptib_pkg for the weight width.
interface ptib_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] p_x;
    logic signed [COORD_BITS-1:0] p_y;

    modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y, input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y, output ready);
endinterface

interface ptib_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  inside_res;
    logic                                  degenerate;
    logic signed [ptib_pkg::WEIGHT_BITS-1:0] weight_a;
    logic signed [ptib_pkg::WEIGHT_BITS-1:0] weight_b;
    logic signed [ptib_pkg::WEIGHT_BITS-1:0] weight_c;

    modport source (output valid, inside_res, degenerate, weight_a, weight_b, weight_c,
                    input ready);
    modport sink   (input valid, inside_res, degenerate, weight_a, weight_b, weight_c,
                    output ready);
endinterface

[hdl/ptib_edge.sv]
// Three-stage edge function pipeline: differences, products, edge values.
// No package dependency.
module ptib_edge #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [COORD_BITS-1:0]   i_a_x,
    input  logic signed [COORD_BITS-1:0]   i_a_y,
    input  logic signed [COORD_BITS-1:0]   i_b_x,
    input  logic signed [COORD_BITS-1:0]   i_b_y,
    input  logic signed [COORD_BITS-1:0]   i_c_x,
    input  logic signed [COORD_BITS-1:0]   i_c_y,
    input  logic signed [COORD_BITS-1:0]   i_p_x,
    input  logic signed [COORD_BITS-1:0]   i_p_y,
    output logic signed [2*COORD_BITS+2:0] o_abp,
    output logic signed [2*COORD_BITS+2:0] o_bcp,
    output logic signed [2*COORD_BITS+2:0] o_cap
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int EW = PW + 1;

    // index 0: AB edge, 1: BC edge, 2: CA edge
    logic signed [DW-1:0] r_pux [3];
    logic signed [DW-1:0] r_puy [3];
    logic signed [DW-1:0] r_vux [3];
    logic signed [DW-1:0] r_vuy [3];
    logic signed [PW-1:0] r_m0  [3];
    logic signed [PW-1:0] r_m1  [3];
    logic signed [EW-1:0] r_e   [3];

    // stage 1: coordinate differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pux[0] <= DW'(i_p_x) - DW'(i_a_x);
            r_puy[0] <= DW'(i_p_y) - DW'(i_a_y);
            r_vux[0] <= DW'(i_b_x) - DW'(i_a_x);
            r_vuy[0] <= DW'(i_b_y) - DW'(i_a_y);
            r_pux[1] <= DW'(i_p_x) - DW'(i_b_x);
            r_puy[1] <= DW'(i_p_y) - DW'(i_b_y);
            r_vux[1] <= DW'(i_c_x) - DW'(i_b_x);
            r_vuy[1] <= DW'(i_c_y) - DW'(i_b_y);
            r_pux[2] <= DW'(i_p_x) - DW'(i_c_x);
            r_puy[2] <= DW'(i_p_y) - DW'(i_c_y);
            r_vux[2] <= DW'(i_a_x) - DW'(i_c_x);
            r_vuy[2] <= DW'(i_a_y) - DW'(i_c_y);
        end
    end

    // stages 2 and 3: cross products, then their difference
    for (genvar g = 0; g < 3; g++) begin : g_edge
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m0[g] <= PW'(r_pux[g]) * PW'(r_vuy[g]);
                r_m1[g] <= PW'(r_puy[g]) * PW'(r_vux[g]);
                r_e[g]  <= EW'(r_m0[g]) - EW'(r_m1[g]);
            end
        end
    end

    assign o_abp = r_e[0];
    assign o_bcp = r_e[1];
    assign o_cap = r_e[2];
endmodule

[hdl/ptib_div_lane.sv]
// Pipelined restoring divider lane, one quotient bit per stage, with saturation tags.
// Depends on ptib_pkg (t_div_ctl).
module ptib_div_lane #(
    parameter int RW = 72,
    parameter int QW = 20
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [RW-1:0]       i_num,
    input  logic [RW-1:0]       i_den,
    input  ptib_pkg::t_div_ctl  i_ctl,
    output logic [QW-1:0]       o_q,
    output ptib_pkg::t_div_ctl  o_ctl
);
    // entry j is the register after step j
    logic [RW-1:0]      r_rem [QW];
    logic [RW-1:0]      r_den [QW];
    logic [QW-1:0]      r_q   [QW];
    ptib_pkg::t_div_ctl r_ctl [QW];

    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int SH = QW - 1 - j;
        logic [RW-1:0]      rem_in;
        logic [RW-1:0]      den_in;
        logic [QW-1:0]      q_in;
        ptib_pkg::t_div_ctl ctl_in;
        logic [RW-1:0]      dsh;
        logic               ge;
        logic [QW-1:0]      n_q;

        // step inputs: lane input for the first step, previous register otherwise
        if (j == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
            assign ctl_in = i_ctl;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign q_in   = r_q[j-1];
            assign ctl_in = r_ctl[j-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        always_comb begin
            dsh     = den_in << SH;
            ge      = rem_in >= dsh;
            n_q     = q_in;
            n_q[SH] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? rem_in - dsh : rem_in;
                r_den[j] <= den_in;
                r_q[j]   <= n_q;
                r_ctl[j] <= ctl_in;
            end
        end
    end

    assign o_q   = r_q[QW-1];
    assign o_ctl = r_ctl[QW-1];
endmodule

[hdl/point_in_triangle_barycentric_top.sv]
// Top level: edge pipeline, area and sign stages, three divider lanes, saturating output.
// Depends on ptib_pkg, ptib_if, ptib_edge and ptib_div_lane.
//
// Usage:
//   i_in carries one sample word per handshake: vertices A, B, C and point P as
//   signed fixed-point coordinates. o_out returns one result word per sample:
//   inside flag, degenerate flag and three signed Q3.16 barycentric weights.
//   Words leave in the order they enter.
//   From acceptance to o_out.valid a word passes the edge stages, the area/sign
//   stages, the divider stages and the saturation/output register.
//   Throughput is one word per cycle while o_out is not stalled; the three
//   divider lanes are fully pipelined with one restoring quotient bit per stage.
//   The whole pipeline advances together. When the receiver holds o_out.ready
//   low while a word waits, i_in.ready drops and every stage freezes; nothing
//   is lost or repeated.
//   Synchronous reset clears all valid bits; no word is presented after reset
//   until one is accepted.
module point_in_triangle_barycentric_top #(
    parameter int COORD_BITS       = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ptib_in_if.sink         i_in,
    ptib_out_if.source      o_out
);
    localparam int WB    = ptib_pkg::WEIGHT_BITS;
    localparam int EW    = 2 * COORD_BITS + 3;
    localparam int SW    = EW + 2;
    localparam int RW    = SW + WEIGHT_FRAC_BITS + WB;
    localparam int DEPTH = WB + 7;

    logic en;
    logic r_vld [DEPTH];

    // global advance: move when the output register is free or drains
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stages 1-3: edge functions
    logic signed [EW-1:0] abp, bcp, cap;

    ptib_edge #(.COORD_BITS(COORD_BITS)) u_edge (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a_x (i_in.a_x), .i_a_y (i_in.a_y),
        .i_b_x (i_in.b_x), .i_b_y (i_in.b_y),
        .i_c_x (i_in.c_x), .i_c_y (i_in.c_y),
        .i_p_x (i_in.p_x), .i_p_y (i_in.p_y),
        .o_abp (abp),
        .o_bcp (bcp),
        .o_cap (cap)
    );

    // stage 4: area sum (lane order A, B, C uses BCP, CAP, ABP)
    logic signed [EW-1:0] r_e4 [3];
    logic signed [SW-1:0] r_s4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e4[0] <= bcp;
            r_e4[1] <= cap;
            r_e4[2] <= abp;
            r_s4    <= SW'(abp) + SW'(bcp) + SW'(cap);
        end
    end

    // stage 5: magnitudes, signs and inside test
    logic [EW-1:0] r_ea5 [3];
    logic          r_en5 [3];
    logic [SW-1:0] r_sa5;
    logic          r_sn5;
    ptib_pkg::t_side r_side5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_ea5[k] <= r_e4[k][EW-1] ? EW'(-r_e4[k]) : EW'(r_e4[k]);
                r_en5[k] <= r_e4[k][EW-1];
            end
            r_sa5 <= r_s4[SW-1] ? SW'(-r_s4) : SW'(r_s4);
            r_sn5 <= r_s4[SW-1];
            r_side5.degen  <= (r_s4 == '0);
            r_side5.in_tri <= !r_e4[0][EW-1] && !r_e4[1][EW-1] && !r_e4[2][EW-1]
                              && !r_s4[SW-1] && (r_s4 != '0);
        end
    end

    // stage 6: scaled dividend and quotient overflow check
    logic [RW-1:0]      r_num6 [3];
    logic [RW-1:0]      r_den6;
    ptib_pkg::t_div_ctl r_ctl6 [3];
    ptib_pkg::t_side    r_side6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_num6[k]     <= RW'(r_ea5[k]) << WEIGHT_FRAC_BITS;
                r_ctl6[k].neg <= r_en5[k] ^ r_sn5;
                r_ctl6[k].ovf <= (RW'(r_ea5[k]) << WEIGHT_FRAC_BITS)
                                 >= (RW'(r_sa5) << WB);
            end
            r_den6  <= RW'(r_sa5);
            r_side6 <= r_side5;
        end
    end

    // divider lanes
    logic [WB-1:0]      q   [3];
    ptib_pkg::t_div_ctl qct [3];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        ptib_div_lane #(.RW(RW), .QW(WB)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num6[g]),
            .i_den (r_den6),
            .i_ctl (r_ctl6[g]),
            .o_q   (q[g]),
            .o_ctl (qct[g])
        );
    end

    // flags ride alongside the dividers
    ptib_pkg::t_side r_side_d [WB];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_d[0] <= r_side6;
            for (int k = 1; k < WB; k++) r_side_d[k] <= r_side_d[k-1];
        end
    end

    // saturation to the signed weight range; a degenerate sample gives zero weights
    localparam logic [WB-1:0] WMAX = {1'b0, {(WB-1){1'b1}}};
    localparam logic [WB-1:0] WMIN = {1'b1, {(WB-1){1'b0}}};

    logic [WB-1:0] wsat [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_side_d[WB-1].degen) begin
                wsat[k] = '0;
            end else if (qct[k].neg) begin
                wsat[k] = (qct[k].ovf || q[k] > WMIN) ? WMIN : WB'(-q[k]);
            end else begin
                wsat[k] = (qct[k].ovf || q[k][WB-1]) ? WMAX : q[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out.inside_res <= r_side_d[WB-1].in_tri;
            o_out.degenerate <= r_side_d[WB-1].degen;
            o_out.weight_a   <= wsat[0];
            o_out.weight_b   <= wsat[1];
            o_out.weight_c   <= wsat[2];
        end
    end

    assign o_out.valid = r_vld[DEPTH-1];

    // checks
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.degenerate |->
            o_out.weight_a == '0 && o_out.weight_b == '0 && o_out.weight_c == '0
            && !o_out.inside_res)
        else $error("degenerate result with nonzero weights or inside set");

    a_inside_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.inside_res |->
            !o_out.weight_a[WB-1] && !o_out.weight_b[WB-1] && !o_out.weight_c[WB-1])
        else $error("inside sample with a negative weight");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
endmodule

[tb/sv/point_in_triangle_barycentric_top_test.sv]
// Testbench for point_in_triangle_barycentric_top: random and directed sample words,
// a behavioral predictor of edge functions and weights, and an in-order result check.
// Depends on ptib_pkg, ptib_if and the block itself.
module point_in_triangle_barycentric_top_test;

    localparam int CB = 16;
    localparam int FRAC = 16;
    localparam int WBITS = ptib_pkg::WEIGHT_BITS;

    typedef struct packed {
        logic signed [CB-1:0] ax, ay, bx, by, cx, cy, px, py;
    } t_sample;

    typedef struct packed {
        logic                    in_tri;
        logic                    degen;
        logic signed [WBITS-1:0] wa, wb, wc;
    } t_weights;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ptib_in_if #(.COORD_BITS(CB)) in_ch ();
    ptib_out_if out_ch ();

    point_in_triangle_barycentric_top #(.COORD_BITS(CB), .WEIGHT_FRAC_BITS(FRAC)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_sample  sample_q[$];
    t_weights weights_q[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       hold_off = 1'b0;
    bit       in_fire = 1'b0;
    int       n_errors = 0;

    // Exact truncated quotient e*2^FRAC/s, saturated to the weight width
    function automatic logic signed [WBITS-1:0] bary_weight(longint e, longint s);
        longint q;
        longint maxv;
        maxv = (longint'(1) << (WBITS - 1)) - 1;
        q = (e * (longint'(1) << FRAC)) / s;
        if (q > maxv) q = maxv;
        if (q < -maxv - 1) q = -maxv - 1;
        return q[WBITS-1:0];
    endfunction

    function automatic longint edge_val(longint ux, longint uy, longint vx, longint vy,
                                        longint px, longint py);
        return (px - ux) * (vy - uy) - (py - uy) * (vx - ux);
    endfunction

    function automatic t_weights predict_weights(t_sample s);
        t_weights r;
        longint abp, bcp, cap, sum;
        abp = edge_val(s.ax, s.ay, s.bx, s.by, s.px, s.py);
        bcp = edge_val(s.bx, s.by, s.cx, s.cy, s.px, s.py);
        cap = edge_val(s.cx, s.cy, s.ax, s.ay, s.px, s.py);
        sum = abp + bcp + cap;
        r.in_tri = (abp >= 0 && bcp >= 0 && cap >= 0 && sum > 0);
        r.degen = (sum == 0);
        if (sum == 0) begin
            r.wa = '0; r.wb = '0; r.wc = '0;
        end else begin
            r.wa = bary_weight(bcp, sum);
            r.wb = bary_weight(cap, sum);
            r.wc = bary_weight(abp, sum);
        end
        return r;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord(int span);
        logic signed [CB-1:0] v;
        case ($urandom_range(0, 3))
            0: v = CB'($urandom);
            1: v = CB'(int'($urandom_range(0, 2*span)) - span);
            2: v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: v = CB'(int'($urandom_range(0, 64)) - 32);
        endcase
        return v;
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        int span;
        span = $urandom_range(0, 1) ? 200 : 4000;
        s.ax = rand_coord(span); s.ay = rand_coord(span);
        s.bx = rand_coord(span); s.by = rand_coord(span);
        s.cx = rand_coord(span); s.cy = rand_coord(span);
        // point mostly near the centroid so inside/outside both occur
        if ($urandom_range(0, 3) != 0) begin
            s.px = CB'((longint'(s.ax) + s.bx + s.cx) / 3
                       + longint'($urandom_range(0, 40)) - 20);
            s.py = CB'((longint'(s.ay) + s.by + s.cy) / 3
                       + longint'($urandom_range(0, 40)) - 20);
        end else begin
            s.px = CB'($urandom); s.py = CB'($urandom);
        end
        if ($urandom_range(0, 9) == 0) begin
            // collinear vertices give a zero area
            s.cx = s.bx; s.cy = s.by;
        end
        return s;
    endfunction

    function automatic t_sample mk(int ax, int ay, int bx, int by, int cx, int cy,
                                   int px, int py);
        t_sample s;
        s.ax = CB'(ax); s.ay = CB'(ay); s.bx = CB'(bx); s.by = CB'(by);
        s.cx = CB'(cx); s.cy = CB'(cy); s.px = CB'(px); s.py = CB'(py);
        return s;
    endfunction

    // Input handshake seen at the rising edge, used by the driver
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    // Driver: offers the head of the pending queue and drives out_ch.ready, changes at falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            {in_ch.a_x, in_ch.a_y, in_ch.b_x, in_ch.b_y,
             in_ch.c_x, in_ch.c_y, in_ch.p_x, in_ch.p_y} <= '0;
            out_ch.ready <= 1'b0;
        end else begin
            if (in_fire) begin
                void'(sample_q.pop_front());
            end
            if (sample_q.size() > 0
                && ($urandom_range(0, 99) >= send_idle_pct || (in_ch.valid && !in_fire))) begin
                in_ch.valid <= 1'b1;
                {in_ch.a_x, in_ch.a_y, in_ch.b_x, in_ch.b_y,
                 in_ch.c_x, in_ch.c_y, in_ch.p_x, in_ch.p_y} <= sample_q[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
            out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Accepted samples feed the predictor; results are checked in order
    always @(posedge i_clk) begin
        t_weights got;
        t_weights want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                weights_q.push_back(predict_weights({in_ch.a_x, in_ch.a_y, in_ch.b_x,
                    in_ch.b_y, in_ch.c_x, in_ch.c_y, in_ch.p_x, in_ch.p_y}));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.inside_res, out_ch.degenerate, out_ch.weight_a,
                       out_ch.weight_b, out_ch.weight_c};
                if (weights_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result word %h", got);
                end else begin
                    want = weights_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: exp in=%b dg=%b wa=%0d wb=%0d wc=%0d / got in=%b dg=%b wa=%0d wb=%0d wc=%0d",
                                want.in_tri, want.degen, want.wa, want.wb, want.wc,
                                got.in_tri, got.degen, got.wa, got.wb, got.wc);
                    end
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (80) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Stimulus phases
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: inside, on edge, outside, clockwise, degenerate, extremes
        sample_q.push_back(mk(0, 0, 160, 0, 0, 160, 16, 16));
        sample_q.push_back(mk(0, 0, 0, 160, 160, 0, 16, 16));
        sample_q.push_back(mk(0, 0, 160, 0, 0, 160, 80, 0));
        sample_q.push_back(mk(0, 0, 160, 0, 0, 160, 0, 0));
        sample_q.push_back(mk(0, 0, 160, 0, 0, 160, 500, 500));
        sample_q.push_back(mk(0, 0, 16, 16, 32, 32, 5, 5));
        sample_q.push_back(mk(7, 7, 7, 7, 7, 7, 7, 7));
        sample_q.push_back(mk(0, 0, 1, 0, 0, 1, 32767, 32767));
        sample_q.push_back(mk(0, 0, 1, 0, 0, 1, -32768, -32768));
        sample_q.push_back(mk(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
        sample_q.push_back(mk(32767, 32767, -32768, 32767, 32767, -32768, -32768, 32767));
        sample_q.push_back(mk(-1, -1, -1, -1, 0, 0, -1, 0));
        sample_q.push_back(mk(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
        sample_q.push_back(mk(0, 0, 3, 0, 0, 3, 1, 1));
        sample_q.push_back(mk(0, 0, 1, 0, 0, 1, -32768, 32767));

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 68 : 0;
            recv_stall_pct = (ph == 2) ? 68 : (ph == 3 ? 22 : 0);
            if (ph == 3) send_idle_pct = 22;
            for (int i = 0; i < 125; i++) sample_q.push_back(rand_sample());
            wait (sample_q.size() == 0);
        end
        wait (weights_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0 && weights_q.size() == 0) begin
            $display("PASS point_in_triangle_barycentric_top");
        end else begin
            $display("FAIL point_in_triangle_barycentric_top");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAIL point_in_triangle_barycentric_top");
        $finish;
    end
endmodule
